// File: sv/trgb_pkg.sv
package trgb_pkg;

   // Register map of the configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_ACROSS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_DOWN   = 1'd1;

   // Field widths
   localparam int TEXEL_W     = 16;
   localparam int RGBA_W      = 32;
   localparam int PIX_INDEX_W = 20;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Widen a 5-bit channel to 8 bits by bit replication
   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   // Widen a 6-bit channel to 8 bits by bit replication
   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // Byte-swap a little-endian RGB565 texel and expand it to RGBA8888
   function automatic logic [RGBA_W-1:0] rgb565_to_rgba(input logic [TEXEL_W-1:0] raw);
      logic [TEXEL_W-1:0] word;
      word = {raw[7:0], raw[15:8]};
      return {ALPHA_OPAQUE, widen5(word[4:0]), widen6(word[10:5]), widen5(word[15:11])};
   endfunction

endpackage

// File: sv/trgb_ifs.sv
// Texel word channel
interface trgb_req_if
   import trgb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [TEXEL_W-1:0] encoded_word;

   modport source (output valid, output encoded_word, input ready);
   modport sink   (input valid, input encoded_word, output ready);
endinterface

// Decoded pixel channel
interface trgb_rsp_if
   import trgb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [RGBA_W-1:0]      pixel_rgba;
   logic [PIX_INDEX_W-1:0] pixel_index;
   logic                   image_last;

   modport source (output valid, output pixel_rgba, output pixel_index, output image_last,
                   input ready);
   modport sink   (input valid, input pixel_rgba, input pixel_index, input image_last,
                   output ready);
endinterface

// File: sv/tiled_rgb565_to_rgba8888.sv
// Tiled RGB565 to RGBA8888 texture decoder.
//
// The req channel takes one little-endian RGB565 texel word per transfer, in
// 4x4 tile order: four pixels of a tile row, then four rows, tiles across the
// image and then down. The rsp channel returns one word per texel: the
// RGBA8888 pixel (red in the low byte, alpha 255), its raster index
// row * width + column (20 bits), and image_last on the final pixel, after
// which the position counters start over at the first pixel.
// The image size in tiles is set through the csr port (index 0: tiles across,
// index 1: tiles down); the user must write it only while no word is in flight,
// which the block itself does not enforce. Zero counts as one and values above
// MAX_TILES_PER_SIDE count as the maximum. rsp.valid rises in the cycle after
// acceptance; the decode and the index multiply-add sit between the input and
// the single output register, and a word is accepted every cycle unless the
// receiver stalls. When it stalls, the output register holds its word and
// req.ready follows rsp.ready, so a new word is taken in the same cycle the
// held one leaves. Synchronous reset empties the output register, sets both
// sizes to one tile and returns the counters to the first pixel.
module tiled_rgb565_to_rgba8888
   import trgb_pkg::*;
#(
   parameter int MAX_TILES_PER_SIDE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   trgb_req_if.sink               req,
   trgb_rsp_if.source             rsp,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TW  = (MAX_TILES_PER_SIDE > 1) ? $clog2(MAX_TILES_PER_SIDE) : 1;
   localparam int EW0 = $clog2(MAX_TILES_PER_SIDE + 1);
   localparam int EW  = (EW0 > CSR_DATA_W) ? EW0 : CSR_DATA_W;
   localparam int PW  = TW + 2 + EW + 2;
   localparam int SW  = (PW > PIX_INDEX_W) ? PW + 1 : PIX_INDEX_W + 1;
   localparam logic [EW-1:0] MAX_EFF = EW'(MAX_TILES_PER_SIDE);

   logic [CSR_DATA_W-1:0]  tiles_across_ff, tiles_down_ff;
   logic [TW-1:0]          tile_col_ff, tile_col_in;
   logic [TW-1:0]          tile_row_ff, tile_row_in;
   logic [1:0]             row_in_tile_ff, row_in_tile_in;
   logic [1:0]             pix_in_row_ff, pix_in_row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RGBA_W-1:0]      rgba_ff;
   logic [PIX_INDEX_W-1:0] index_ff;
   logic                   last_ff;

   logic [EW-1:0]          across_eff, down_eff;
   logic                   req_fire;
   logic                   last_col, last_row, last_pixel;
   logic [TW+1:0]          row_pos, col_pos;
   logic [EW+1:0]          width_px;
   logic [PW-1:0]          row_base;
   logic [SW-1:0]          index_sum;

   // Clamp a size register to the supported range
   function automatic logic [EW-1:0] eff_tiles(input logic [CSR_DATA_W-1:0] r);
      logic [EW-1:0] w;
      w = EW'(r);
      if (w == '0) begin
         return EW'(1);
      end else if (w > MAX_EFF) begin
         return MAX_EFF;
      end
      return w;
   endfunction

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_across_ff <= CSR_DATA_W'(1);
         tiles_down_ff   <= CSR_DATA_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TILES_ACROSS: tiles_across_ff <= csr_wdata;
            CSR_TILES_DOWN:   tiles_down_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign across_eff = eff_tiles(tiles_across_ff);
   assign down_eff   = eff_tiles(tiles_down_ff);

   // Accept whenever the output register is empty or leaving
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   // Position of the current word
   assign last_col   = ((EW+1)'(tile_col_ff) + (EW+1)'(1)) >= (EW+1)'(across_eff);
   assign last_row   = ((EW+1)'(tile_row_ff) + (EW+1)'(1)) >= (EW+1)'(down_eff);
   assign last_pixel = (pix_in_row_ff == 2'd3) && (row_in_tile_ff == 2'd3)
                       && last_col && last_row;

   // Raster index: row * width + column, kept to 20 bits
   assign row_pos   = {tile_row_ff, row_in_tile_ff};
   assign col_pos   = {tile_col_ff, pix_in_row_ff};
   assign width_px  = {across_eff, 2'b00};
   assign row_base  = PW'(row_pos) * PW'(width_px);
   assign index_sum = SW'(row_base) + SW'(col_pos);

   // Advance the tile walk on each accepted word
   always_comb begin
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      row_in_tile_in = row_in_tile_ff;
      pix_in_row_in  = pix_in_row_ff;
      if (req_fire) begin
         pix_in_row_in = pix_in_row_ff + 2'd1;
         if (pix_in_row_ff == 2'd3) begin
            row_in_tile_in = row_in_tile_ff + 2'd1;
            if (row_in_tile_ff == 2'd3) begin
               if (!last_col) begin
                  tile_col_in = tile_col_ff + TW'(1);
               end else begin
                  tile_col_in = '0;
                  tile_row_in = last_row ? '0 : tile_row_ff + TW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_col_ff    <= '0;
         tile_row_ff    <= '0;
         row_in_tile_ff <= '0;
         pix_in_row_ff  <= '0;
      end else begin
         tile_col_ff    <= tile_col_in;
         tile_row_ff    <= tile_row_in;
         row_in_tile_ff <= row_in_tile_in;
         pix_in_row_ff  <= pix_in_row_in;
      end
   end

   // Output register: load on accept, drop when taken
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rgba_ff  <= rgb565_to_rgba(req.encoded_word);
         index_ff <= index_sum[PIX_INDEX_W-1:0];
         last_ff  <= last_pixel;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_rgba  = rgba_ff;
   assign rsp.pixel_index = index_ff;
   assign rsp.image_last  = last_ff;

   // The last pixel of an image is always the last column of a tile
   a_last_in_tile_corner: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.image_last |-> rsp.pixel_index[1:0] == 2'd3)
      else $error("image_last on a pixel that is not a tile row end");

   // After the last pixel the walk restarts at the origin
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && last_pixel |=> (tile_col_ff == '0 && tile_row_ff == '0
                                  && row_in_tile_ff == 2'd0 && pix_in_row_ff == 2'd0))
      else $error("counters did not restart after the last pixel");

   // Within a tile row the pixel counter steps by one per accepted word
   a_pixel_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && pix_in_row_ff != 2'd3 |=> pix_in_row_ff == $past(pix_in_row_ff) + 2'd1
                                             && row_in_tile_ff == $past(row_in_tile_ff))
      else $error("pixel counter did not advance by one");

   // Every result carries an opaque alpha
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.pixel_rgba[31:24] == ALPHA_OPAQUE)
      else $error("alpha byte is not opaque");

endmodule
